// ----- hw/rtl/mpss_pkg.sv -----
// Shared types, codes and the element compare for the multi-pattern shift-or scanner.
package mpss_pkg;

  localparam int LEN_W = 6;

  typedef enum logic [1:0] {
    CMD_WRITE   = 2'd0,
    CMD_SCAN    = 2'd1,
    CMD_RESTART = 2'd2
  } cmd_t;

  localparam logic [1:0] CFG_CASE_INS  = 2'd0;
  localparam logic [1:0] CFG_WILDCARDS = 2'd1;
  localparam logic [1:0] CFG_SCAN_LIM  = 2'd2;

  localparam logic [7:0] CH_NUL   = 8'h00;
  localparam logic [7:0] CH_HASH  = 8'h23;
  localparam logic [7:0] CH_AT    = 8'h40;
  localparam logic [7:0] CH_DIG0  = 8'h30;
  localparam logic [7:0] CH_DIG9  = 8'h39;
  localparam logic [7:0] CH_UP_A  = 8'h41;
  localparam logic [7:0] CH_UP_Z  = 8'h5A;
  localparam logic [7:0] CH_LO_A  = 8'h61;
  localparam logic [7:0] CH_LO_Z  = 8'h7A;
  localparam logic [7:0] CASE_BIT = 8'h20;

  typedef struct packed {
    logic [1:0] command;
    logic [1:0] pattern_sel;
    logic [4:0] position;
    logic [7:0] char_code;
    logic       last_element;
  } in_item_t;

  typedef struct packed {
    logic        found;
    logic [1:0]  pattern_id;
    logic [15:0] start_pos;
    logic        scan_done;
  } out_item_t;

  // Control broadcast to every cell of the chain
  typedef struct packed {
    logic       advance;
    logic       restart;
    logic       wr_en;
    logic [4:0] wr_pos;
    logic [7:0] char_code;
    logic       case_ins;
    logic       wildcards;
  } cell_ctl_t;

  function automatic logic elem_match(input logic [7:0] e, input logic [7:0] c,
                                      input logic ci, input logic wc);
    logic c_dig, c_let, e_let;
    c_dig = (c >= CH_DIG0) && (c <= CH_DIG9);
    c_let = ((c >= CH_UP_A) && (c <= CH_UP_Z)) || ((c >= CH_LO_A) && (c <= CH_LO_Z));
    e_let = ((e >= CH_UP_A) && (e <= CH_UP_Z)) || ((e >= CH_LO_A) && (e <= CH_LO_Z));
    if (wc && (e == CH_HASH)) begin
      elem_match = c_dig;
    end else if (wc && (e == CH_AT)) begin
      elem_match = c_let;
    end else begin
      // letters differ from their other case only in bit 5
      elem_match = (c == e) || (ci && e_let && (c == (e ^ CASE_BIT)));
    end
  endfunction

endpackage

// ----- hw/rtl/multi_pattern_shift_or_scanner_core.sv -----
// Multi-pattern shift-or scanner: control, cell chain and result buffer.
// Each accepted input item yields a result item, registered in the output buffer or parked in its skid stage.
// Throughput: one item per cycle while in_ready is high; every pattern position compares in its own cell.
// in_ready drops only while the skid stage holds an item the output has not taken.
// Synchronous active-low reset clears histories, lengths, text index, stop flag and
// registers (wildcards on, scan limit 65535); stored pattern elements are not cleared.
module multi_pattern_shift_or_scanner_core import mpss_pkg::*; #(
  parameter int NUM_PATTERNS = 4,
  parameter int PATTERN_LEN  = 32
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_ready,
  input  in_item_t  in_item,
  output logic      out_valid,
  input  logic      out_ready,
  output out_item_t out_item,
  input  logic      cfg_valid,
  output logic      cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_data
);

  logic        case_ins_r, case_ins_nxt;
  logic        wildcards_r, wildcards_nxt;
  logic [15:0] scan_lim_r, scan_lim_nxt;
  logic [15:0] text_idx_r, text_idx_nxt;
  logic        stopped_r, stopped_nxt;
  logic [NUM_PATTERNS-1:0][LEN_W-1:0] len_r, len_nxt;

  logic        in_fire;
  logic        wr_ok;
  logic        scan_live;
  logic        scan_go;
  logic        found_c;
  logic [1:0]  pid_c;
  logic [LEN_W-1:0] hit_len;
  logic [NUM_PATTERNS-1:0] wr_mask;
  logic [NUM_PATTERNS-1:0] done;
  logic [NUM_PATTERNS-1:0] hist_chain [PATTERN_LEN+1];
  logic [PATTERN_LEN-1:0][NUM_PATTERNS-1:0] tails;
  cell_ctl_t   ctl;
  out_item_t   res;

  assign cfg_ready = 1'b1;
  assign in_fire   = in_valid && in_ready;

  always_comb begin
    wr_ok     = in_fire && (in_item.command == CMD_WRITE) &&
                (32'(in_item.pattern_sel) < NUM_PATTERNS) &&
                (32'(in_item.position) < PATTERN_LEN);
    scan_live = in_fire && (in_item.command == CMD_SCAN) && !stopped_r;
    scan_go   = scan_live && (in_item.char_code != CH_NUL) && (text_idx_r < scan_lim_r);
    for (int j = 0; j < NUM_PATTERNS; j++) begin
      wr_mask[j] = (32'(in_item.pattern_sel) == j);
    end
    ctl.advance   = scan_go;
    ctl.restart   = in_fire && (in_item.command == CMD_RESTART);
    ctl.wr_en     = wr_ok;
    ctl.wr_pos    = in_item.position;
    ctl.char_code = in_item.char_code;
    ctl.case_ins  = case_ins_r;
    ctl.wildcards = wildcards_r;
  end

  assign hist_chain[0] = '0;

  for (genvar i = 0; i < PATTERN_LEN; i++) begin : g_cell
    mpss_cell #(
      .NUM_PATTERNS (NUM_PATTERNS),
      .IDX          (i)
    ) u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .ctl      (ctl),
      .wr_mask  (wr_mask),
      .lengths  (len_r),
      .hist_in  (hist_chain[i]),
      .hist_out (hist_chain[i+1]),
      .tail_hit (tails[i])
    );
  end

  // Pick the lowest completing pattern
  always_comb begin
    done    = '0;
    for (int i = 0; i < PATTERN_LEN; i++) begin
      done = done | tails[i];
    end
    found_c = 1'b0;
    pid_c   = '0;
    hit_len = '0;
    for (int j = NUM_PATTERNS - 1; j >= 0; j--) begin
      if (scan_go && done[j]) begin
        found_c = 1'b1;
        pid_c   = 2'(j);
        hit_len = len_r[j];
      end
    end
  end

  always_comb begin
    case_ins_nxt  = case_ins_r;
    wildcards_nxt = wildcards_r;
    scan_lim_nxt  = scan_lim_r;
    if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_CASE_INS:  case_ins_nxt  = cfg_data[0];
        CFG_WILDCARDS: wildcards_nxt = cfg_data[0];
        CFG_SCAN_LIM:  scan_lim_nxt  = cfg_data;
        default: ;
      endcase
    end
  end

  always_comb begin
    len_nxt      = len_r;
    text_idx_nxt = text_idx_r;
    stopped_nxt  = stopped_r;
    if (wr_ok && in_item.last_element) begin
      len_nxt[in_item.pattern_sel] = LEN_W'(in_item.position) + LEN_W'(1);
    end
    if (ctl.restart) begin
      text_idx_nxt = '0;
      stopped_nxt  = 1'b0;
    end else if (scan_go) begin
      text_idx_nxt = text_idx_r + 16'd1;
      stopped_nxt  = found_c;
    end else if (scan_live) begin
      // zero character or limit reached
      stopped_nxt  = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      case_ins_r  <= 1'b0;
      wildcards_r <= 1'b1;
      scan_lim_r  <= 16'hFFFF;
      text_idx_r  <= '0;
      stopped_r   <= 1'b0;
      len_r       <= '0;
    end else begin
      case_ins_r  <= case_ins_nxt;
      wildcards_r <= wildcards_nxt;
      scan_lim_r  <= scan_lim_nxt;
      text_idx_r  <= text_idx_nxt;
      stopped_r   <= stopped_nxt;
      len_r       <= len_nxt;
    end
  end

  always_comb begin
    res.found      = found_c;
    res.pattern_id = pid_c;
    res.start_pos  = found_c ? (text_idx_r + 16'd1 - 16'(hit_len)) : 16'd0;
    res.scan_done  = stopped_nxt;
  end

  mpss_out_buf u_out_buf (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (in_fire),
    .push_item  (res),
    .push_ready (in_ready),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_item   (out_item)
  );

  a_found_stops: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire && found_c |=> stopped_r)
    else $error("match did not stop the scan");

  a_restart_clears: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire && (in_item.command == CMD_RESTART) |=> !stopped_r && (text_idx_r == 16'd0))
    else $error("restart left scan state behind");

  a_stopped_holds: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire && (in_item.command == CMD_SCAN) && stopped_r |=> $stable(text_idx_r))
    else $error("text index moved while stopped");

  a_found_done: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_item.found |-> out_item.scan_done)
    else $error("found item without scan_done");

endmodule

// ----- hw/rtl/mpss_cell.sv -----
// One pattern position: stored elements of every pattern and one history bit each.
module mpss_cell import mpss_pkg::*; #(
  parameter int NUM_PATTERNS = 4,
  parameter int IDX          = 0
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  cell_ctl_t                           ctl,
  input  logic [NUM_PATTERNS-1:0]             wr_mask,
  input  logic [NUM_PATTERNS-1:0][LEN_W-1:0]  lengths,
  input  logic [NUM_PATTERNS-1:0]             hist_in,
  output logic [NUM_PATTERNS-1:0]             hist_out,
  output logic [NUM_PATTERNS-1:0]             tail_hit
);

  localparam logic [LEN_W-1:0] POS  = LEN_W'(IDX);
  localparam logic [LEN_W-1:0] TAIL = LEN_W'(IDX + 1);

  logic [7:0]              elem_r [NUM_PATTERNS];
  logic [NUM_PATTERNS-1:0] hist_r;
  logic [NUM_PATTERNS-1:0] hist_nxt;
  logic [NUM_PATTERNS-1:0] step_bit;

  always_comb begin
    for (int j = 0; j < NUM_PATTERNS; j++) begin
      step_bit[j] = hist_in[j] |
                    !((POS < lengths[j]) &&
                      elem_match(elem_r[j], ctl.char_code, ctl.case_ins, ctl.wildcards));
      // pattern completes when its last position clears
      tail_hit[j] = (lengths[j] == TAIL) && !step_bit[j];
    end
    hist_nxt = hist_r;
    if (ctl.restart) begin
      hist_nxt = '1;
    end else if (ctl.advance) begin
      hist_nxt = step_bit;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hist_r <= '1;
    end else begin
      hist_r <= hist_nxt;
    end
  end

  always_ff @(posedge clk) begin
    for (int j = 0; j < NUM_PATTERNS; j++) begin
      if (ctl.wr_en && wr_mask[j] && (32'(ctl.wr_pos) == IDX)) begin
        elem_r[j] <= ctl.char_code;
      end
    end
  end

  assign hist_out = hist_r;

endmodule

// ----- hw/rtl/mpss_out_buf.sv -----
// Output register with a skid stage for result items.
module mpss_out_buf import mpss_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      push,
  input  out_item_t push_item,
  output logic      push_ready,
  output logic      out_valid,
  input  logic      out_ready,
  output out_item_t out_item
);

  logic      out_valid_r, out_valid_nxt;
  logic      skid_valid_r, skid_valid_nxt;
  out_item_t out_r, out_nxt;
  out_item_t skid_r, skid_nxt;

  always_comb begin
    out_valid_nxt  = out_valid_r;
    skid_valid_nxt = skid_valid_r;
    out_nxt        = out_r;
    skid_nxt       = skid_r;
    if (!out_valid_r || out_ready) begin
      out_valid_nxt  = skid_valid_r || push;
      out_nxt        = skid_valid_r ? skid_r : push_item;
      skid_valid_nxt = 1'b0;
    end else if (push) begin
      // hold the presented item, park the new one
      skid_valid_nxt = 1'b1;
      skid_nxt       = push_item;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else begin
      out_valid_r  <= out_valid_nxt;
      skid_valid_r <= skid_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_r  <= out_nxt;
    skid_r <= skid_nxt;
  end

  assign push_ready = !skid_valid_r;
  assign out_valid  = out_valid_r;
  assign out_item   = out_r;

endmodule
